FILE: hw/rtl/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } opcode_t;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

endpackage

FILE: hw/rtl/lfu_ram.sv
`timescale 1ns / 1ps

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/lfu_cache_table_top.sv
`timescale 1ns / 1ps

// Fully associative key/value cache, DEPTH slots, least-frequently-used
// replacement with least-recently-touched tie break. Pulse start while busy is
// low to issue a get or put; one result word appears on the result ports for
// exactly one cycle, marked by done, and must be captured then. A lookup that
// misses, or a put while capacity is zero, ends after one scan pass; every
// other access also makes a second pass. Both passes are paced by the single
// read port of the slot memory: one scan pass reads every slot for the key,
// the victim and a free slot, and the second read-modify-write pass updates
// ranks, counts and the touched or new entry. Write capacity only while busy
// is low and no result is pending.
module lfu_cache_table_top #(
    parameter int DEPTH      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic signed [lfu_pkg::KEY_W-1:0]   lookup_key,
    input  logic signed [lfu_pkg::VAL_W-1:0]   store_value,
    output logic                               done,
    output logic                               hit,
    output logic signed [lfu_pkg::VAL_W-1:0]   read_value,
    output logic                               evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]   evicted_key
);

    import lfu_pkg::*;

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (IDX_W > CAP_W) ? IDX_W : CAP_W;
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [AW-1:0]         rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [DEPTH-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]     occ_reg, occ_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;

    opcode_t              op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     val_reg, val_next;

    logic                 found_reg, found_next;
    logic [AW-1:0]        s_idx_reg, s_idx_next;
    logic [AW-1:0]        s_rank_reg, s_rank_next;
    logic [VAL_W-1:0]     s_value_reg, s_value_next;

    logic                 free_found_reg, free_found_next;
    logic [AW-1:0]        free_idx_reg, free_idx_next;

    logic                 vic_found_reg, vic_found_next;
    logic [AW-1:0]        vic_idx_reg, vic_idx_next;
    logic [AW-1:0]        vic_rank_reg, vic_rank_next;
    logic [COUNT_BITS-1:0] vic_count_reg, vic_count_next;
    logic [KEY_W-1:0]     vic_key_reg, vic_key_next;

    logic                 touch_reg, touch_next;
    logic                 evict_reg, evict_next;
    logic                 ins_reg, ins_next;
    logic [AW-1:0]        ins_idx_reg, ins_idx_next;

    logic                 done_reg, done_next;
    logic                 hit_reg, hit_next;
    logic [VAL_W-1:0]     rdv_reg, rdv_next;
    logic                 ev_reg, ev_next;
    logic [KEY_W-1:0]     evk_reg, evk_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wentry;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rentry;

    logic                 slot_live;
    logic                 scan_end;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     cap_eff;
    logic [CMP_W-1:0]     occ_ext;
    logic                 full;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rentry   = entry_t'(ram_rdata);
    assign scan_end = (idx_reg == IDX_END) && !rd_valid_reg;
    assign cap_ext  = CMP_W'(cap_reg);
    assign cap_eff  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign occ_ext  = CMP_W'(occ_reg);
    assign full     = (occ_ext >= cap_eff);

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rdv_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        found_next      = found_reg;
        s_idx_next      = s_idx_reg;
        s_rank_next     = s_rank_reg;
        s_value_next    = s_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_rank_next   = vic_rank_reg;
        vic_count_next  = vic_count_reg;
        vic_key_next    = vic_key_reg;
        touch_next      = touch_reg;
        evict_next      = evict_reg;
        ins_next        = ins_reg;
        ins_idx_next    = ins_idx_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        rdv_next        = rdv_reg;
        ev_next         = ev_reg;
        evk_next        = evk_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        ram_wentry      = rentry;
        slot_live       = valid_reg[rd_idx_reg] && !(evict_reg && rd_idx_reg == vic_idx_reg);

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        // issue one slot read per cycle during both passes
        if ((state_reg == ST_SCAN || state_reg == ST_UPDATE) && idx_reg != IDX_END)
        begin
            idx_next      = idx_reg + IDX_W'(1);
            rd_valid_next = 1'b1;
            rd_idx_next   = idx_reg[AW-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode_t'(opcode);
                    key_next        = lookup_key;
                    val_next        = store_value;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    idx_next        = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    if (valid_reg[rd_idx_reg])
                    begin
                        if (!found_reg && rentry.key == key_reg)
                        begin
                            found_next   = 1'b1;
                            s_idx_next   = rd_idx_reg;
                            s_rank_next  = rentry.rank;
                            s_value_next = rentry.value;
                        end
                        // lowest count wins, least recent among equals
                        if (!vic_found_reg || rentry.count < vic_count_reg ||
                            (rentry.count == vic_count_reg && rentry.rank > vic_rank_reg))
                        begin
                            vic_found_next = 1'b1;
                            vic_idx_next   = rd_idx_reg;
                            vic_rank_next  = rentry.rank;
                            vic_count_next = rentry.count;
                            vic_key_next   = rentry.key;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
                if (scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                hit_next   = found_reg;
                ev_next    = 1'b0;
                evk_next   = '0;
                touch_next = 1'b0;
                evict_next = 1'b0;
                ins_next   = 1'b0;
                idx_next   = '0;
                state_next = ST_FINISH;
                if (op_reg == OP_GET)
                begin
                    rdv_next = found_reg ? s_value_reg : '1;
                    if (found_reg)
                    begin
                        touch_next = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
                else
                begin
                    rdv_next = '0;
                    if (cap_eff != '0)
                    begin
                        if (found_reg)
                        begin
                            touch_next = 1'b1;
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            evict_next = full && vic_found_reg;
                            ev_next    = full && vic_found_reg;
                            evk_next   = (full && vic_found_reg) ? vic_key_reg : '0;
                            ins_next   = (full && vic_found_reg) || free_found_reg;
                            // the freed slot may sit below the first free one
                            if (full && vic_found_reg &&
                                (!free_found_reg || vic_idx_reg < free_idx_reg))
                            begin
                                ins_idx_next = vic_idx_reg;
                            end
                            else
                            begin
                                ins_idx_next = free_idx_reg;
                            end
                            state_next = ST_UPDATE;
                        end
                    end
                end
            end

            ST_UPDATE:
            begin
                if (rd_valid_reg)
                begin
                    if (ins_reg && rd_idx_reg == ins_idx_reg)
                    begin
                        ram_we           = 1'b1;
                        ram_wentry.key   = key_reg;
                        ram_wentry.value = val_reg;
                        ram_wentry.count = COUNT_BITS'(1);
                        ram_wentry.rank  = '0;
                    end
                    else if (slot_live)
                    begin
                        ram_we = 1'b1;
                        if (touch_reg)
                        begin
                            if (rd_idx_reg == s_idx_reg)
                            begin
                                ram_wentry.rank = '0;
                                if (rentry.count != '1)
                                begin
                                    ram_wentry.count = rentry.count + COUNT_BITS'(1);
                                end
                                if (op_reg == OP_PUT)
                                begin
                                    ram_wentry.value = val_reg;
                                end
                            end
                            else if (rentry.rank < s_rank_reg)
                            begin
                                ram_wentry.rank = rentry.rank + AW'(1);
                            end
                        end
                        else
                        begin
                            // close the gap left by the victim, then age by one
                            if (evict_reg && rentry.rank > vic_rank_reg)
                            begin
                                ram_wentry.rank = rentry.rank;
                            end
                            else
                            begin
                                ram_wentry.rank = rentry.rank + AW'(1);
                            end
                        end
                    end
                end
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (evict_reg)
                begin
                    valid_next[vic_idx_reg] = 1'b0;
                end
                if (ins_reg)
                begin
                    valid_next[ins_idx_reg] = 1'b1;
                end
                if (ins_reg && !evict_reg)
                begin
                    occ_next = occ_reg + IDX_W'(1);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            valid_reg      <= '0;
            occ_reg        <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            op_reg         <= OP_GET;
            key_reg        <= '0;
            val_reg        <= '0;
            found_reg      <= 1'b0;
            s_idx_reg      <= '0;
            s_rank_reg     <= '0;
            s_value_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= '0;
            vic_rank_reg   <= '0;
            vic_count_reg  <= '0;
            vic_key_reg    <= '0;
            touch_reg      <= 1'b0;
            evict_reg      <= 1'b0;
            ins_reg        <= 1'b0;
            ins_idx_reg    <= '0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            rdv_reg        <= '0;
            ev_reg         <= 1'b0;
            evk_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            found_reg      <= found_next;
            s_idx_reg      <= s_idx_next;
            s_rank_reg     <= s_rank_next;
            s_value_reg    <= s_value_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            vic_found_reg  <= vic_found_next;
            vic_idx_reg    <= vic_idx_next;
            vic_rank_reg   <= vic_rank_next;
            vic_count_reg  <= vic_count_next;
            vic_key_reg    <= vic_key_next;
            touch_reg      <= touch_next;
            evict_reg      <= evict_next;
            ins_reg        <= ins_next;
            ins_idx_reg    <= ins_idx_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            rdv_reg        <= rdv_next;
            ev_reg         <= ev_next;
            evk_reg        <= evk_next;
        end
    end

`ifndef ASSERT_OFF
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == occ_reg)
        else $error("occupancy does not match valid slots");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result word without a finished access");

    a_evict_only_on_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ev_reg) |-> (op_reg == OP_PUT && !hit_reg))
        else $error("eviction on a get or a hit");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start an access");

    a_no_evict_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && evict_reg) |-> full)
        else $error("eviction while below capacity");
`endif

endmodule
